/* hdl/pwsp_pkg.sv */
package pwsp_pkg;

    localparam int unsigned MAX_MSG_BYTES = 65536;
    localparam int unsigned NS_CAPACITY   = 32;
    localparam int unsigned OFF_W         = $clog2(MAX_MSG_BYTES) + 1;
    localparam int unsigned NS_KEEP       = NS_CAPACITY - 1;
    localparam int unsigned MAX_GROUPS    = 10;

    localparam logic [2:0] ROLE_TAG     = 3'd0;
    localparam logic [2:0] ROLE_VARINT  = 3'd1;
    localparam logic [2:0] ROLE_LENGTH  = 3'd2;
    localparam logic [2:0] ROLE_NS      = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
    localparam logic [2:0] ROLE_SKIP    = 3'd5;
    localparam logic [2:0] ROLE_ERROR   = 3'd6;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    localparam logic [31:0] FIELD_NAMESPACE = 32'd4;
    localparam logic [31:0] FIELD_PTYPE     = 32'd5;
    localparam logic [31:0] FIELD_PAYLOAD   = 32'd6;

    localparam logic [15:0] SKIP_I32 = 16'd4;
    localparam logic [15:0] SKIP_I64 = 16'd8;

endpackage

/* hdl/protobuf_wire_stream_parser.sv */
// protobuf wire format parser, one message byte per beat
// input channel s_*: s_data_byte with s_last_byte marking the final byte of a message
// result channel m_*: one result beat per input beat, in order
//   m_byte_role / m_body_index classify every byte (tag, value, length, body, skip, error)
//   on the beat of the last byte m_done_res is set and m_parse_ok and the summary
//   fields (payload type, offset, length, namespace length) are valid, else they are 0
// result: registered, valid in the cycle after the input beat is accepted
// throughput: one byte per cycle unless the output stalls; the parse state is updated
//   from the byte and the registered state, with the result held in an output register
// stall: s_ready follows m_ready when a result is waiting, so a stalled receiver
//   holds the input side without loss; a new byte is taken while the result is read
// reset: aresetn (synchronous, active low) drops m_valid and returns the parser
//   to the tag phase with all kept values cleared; the same clearing happens
//   after every last byte so each message parses independently
module protobuf_wire_stream_parser
    import pwsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_role,
    output logic [15:0] m_body_index,
    output logic        m_done_res,
    output logic        m_parse_ok,
    output logic [31:0] m_msg_type,
    output logic [15:0] m_payload_offset,
    output logic [15:0] m_payload_length,
    output logic [4:0]  m_namespace_length
);

    localparam logic [2:0] PH_TAG  = 3'd0;
    localparam logic [2:0] PH_VAL  = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;

    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_MSG_BYTES);

    // parse state
    logic [2:0]       phase_reg, phase_next;
    logic [63:0]      acc_reg, acc_next;
    logic [3:0]       grp_reg, grp_next;
    logic             fld4_reg, fld4_next;
    logic             fld5_reg, fld5_next;
    logic             fld6_reg, fld6_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      pos_reg, pos_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             fail_reg, fail_next;
    logic [31:0]      ktype_reg, ktype_next;
    logic [15:0]      koff_reg, koff_next;
    logic [15:0]      klen_reg, klen_next;
    logic [4:0]       kns_reg, kns_next;

    // result register
    logic        m_valid_reg;
    logic [2:0]  role_reg;
    logic [15:0] idx_reg;
    logic        done_reg;
    logic        ok_reg;
    logic [31:0] otype_reg;
    logic [15:0] ooff_reg;
    logic [15:0] olen_reg;
    logic [4:0]  ons_reg;

    logic [2:0]       role;
    logic [15:0]      idx;
    logic             accept;
    logic [6:0]       shamt;
    logic [63:0]      acc_or;
    logic [31:0]      field;
    logic [OFF_W-1:0] off_inc;
    logic [OFF_W-1:0] room;
    logic             too_big;
    logic [15:0]      ns_min;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign shamt   = 7'(grp_reg) * 7'd7;
    assign acc_or  = acc_reg | (64'(s_data_byte[6:0]) << shamt);
    assign field   = acc_or[34:3];
    assign off_inc = off_reg + OFF_W'(1);
    assign room    = OFF_MAX - off_inc;
    assign too_big = (|acc_or[63:16]) || ({{(OFF_W-16){1'b0}}, acc_or[15:0]} > room);
    assign ns_min  = (acc_or[15:0] < 16'(NS_KEEP)) ? acc_or[15:0] : 16'(NS_KEEP);

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        grp_next   = grp_reg;
        fld4_next  = fld4_reg;
        fld5_next  = fld5_reg;
        fld6_next  = fld6_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        fail_next  = fail_reg;
        ktype_next = ktype_reg;
        koff_next  = koff_reg;
        klen_next  = klen_reg;
        kns_next   = kns_reg;
        role       = ROLE_ERROR;
        idx        = 16'd0;

        if (!fail_reg && off_reg >= OFF_MAX) begin
            fail_next = 1'b1;
        end else if (!fail_reg) begin
            unique case (phase_reg)
                PH_TAG, PH_VAL, PH_LEN: begin
                    role     = (phase_reg == PH_TAG) ? ROLE_TAG :
                               ((phase_reg == PH_VAL) ? ROLE_VARINT : ROLE_LENGTH);
                    acc_next = acc_or;
                    if (s_data_byte[7]) begin
                        grp_next = grp_reg + 4'd1;
                        if (grp_reg == 4'(MAX_GROUPS - 1) || s_last_byte) begin
                            fail_next = 1'b1;
                        end
                    end else begin
                        grp_next = 4'd0;
                        acc_next = 64'd0;
                        if (phase_reg == PH_TAG) begin
                            fld4_next = (field == FIELD_NAMESPACE);
                            fld5_next = (field == FIELD_PTYPE);
                            fld6_next = (field == FIELD_PAYLOAD);
                            unique case (acc_or[2:0])
                                WT_VARINT: begin
                                    phase_next = PH_VAL;
                                    if (s_last_byte) begin
                                        fail_next = 1'b1;
                                    end
                                end
                                WT_LEN: begin
                                    phase_next = PH_LEN;
                                    if (s_last_byte) begin
                                        fail_next = 1'b1;
                                    end
                                end
                                WT_I32: begin
                                    rem_next   = SKIP_I32;
                                    phase_next = PH_SKIP;
                                end
                                WT_I64: begin
                                    rem_next   = SKIP_I64;
                                    phase_next = PH_SKIP;
                                end
                                default: begin
                                    fail_next = 1'b1;
                                end
                            endcase
                        end else if (phase_reg == PH_VAL) begin
                            if (fld5_reg) begin
                                ktype_next = acc_or[31:0];
                            end
                            phase_next = PH_TAG;
                        end else if (too_big) begin
                            fail_next = 1'b1;
                        end else begin
                            if (fld4_reg) begin
                                kns_next = ns_min[4:0];
                            end else if (fld6_reg) begin
                                koff_next = off_inc[15:0];
                                klen_next = acc_or[15:0];
                            end
                            if (acc_or[15:0] == 16'd0) begin
                                phase_next = PH_TAG;
                            end else begin
                                rem_next   = acc_or[15:0];
                                pos_next   = 16'd0;
                                phase_next = PH_BODY;
                                if (s_last_byte) begin
                                    fail_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (fld4_reg) begin
                        role = (pos_reg < 16'(NS_KEEP)) ? ROLE_NS : ROLE_SKIP;
                        idx  = pos_reg;
                    end else if (fld6_reg) begin
                        role = ROLE_PAYLOAD;
                        idx  = pos_reg;
                    end else begin
                        role = ROLE_SKIP;
                    end
                    pos_next = pos_reg + 16'd1;
                    rem_next = rem_reg - 16'd1;
                    if (rem_reg == 16'd1) begin
                        phase_next = PH_TAG;
                    end else if (s_last_byte) begin
                        fail_next = 1'b1;
                    end
                end
                PH_SKIP: begin
                    role = ROLE_SKIP;
                    if (rem_reg != 16'd0) begin
                        rem_next = rem_reg - 16'd1;
                    end
                    if (rem_reg <= 16'd1) begin
                        phase_next = PH_TAG;
                    end
                end
                default: begin
                    phase_next = PH_TAG;
                end
            endcase
        end

        off_next = (off_reg < OFF_MAX) ? off_inc : off_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            role_reg  <= role;
            idx_reg   <= idx;
            done_reg  <= s_last_byte;
            ok_reg    <= s_last_byte && !fail_next;
            otype_reg <= s_last_byte ? ktype_next : 32'd0;
            ooff_reg  <= s_last_byte ? koff_next : 16'd0;
            olen_reg  <= s_last_byte ? klen_next : 16'd0;
            ons_reg   <= s_last_byte ? kns_next : 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_last_byte)) begin
            phase_reg <= PH_TAG;
            acc_reg   <= 64'd0;
            grp_reg   <= 4'd0;
            fld4_reg  <= 1'b0;
            fld5_reg  <= 1'b0;
            fld6_reg  <= 1'b0;
            rem_reg   <= 16'd0;
            pos_reg   <= 16'd0;
            off_reg   <= '0;
            fail_reg  <= 1'b0;
            ktype_reg <= 32'd0;
            koff_reg  <= 16'd0;
            klen_reg  <= 16'd0;
            kns_reg   <= 5'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            grp_reg   <= grp_next;
            fld4_reg  <= fld4_next;
            fld5_reg  <= fld5_next;
            fld6_reg  <= fld6_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            fail_reg  <= fail_next;
            ktype_reg <= ktype_next;
            koff_reg  <= koff_next;
            klen_reg  <= klen_next;
            kns_reg   <= kns_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_byte_role        = role_reg;
    assign m_body_index       = idx_reg;
    assign m_done_res         = done_reg;
    assign m_parse_ok         = ok_reg;
    assign m_msg_type         = otype_reg;
    assign m_payload_offset   = ooff_reg;
    assign m_payload_length   = olen_reg;
    assign m_namespace_length = ons_reg;

endmodule
